@@ rtl/swtq_pkg.sv @@
// Shared types and constants for the sorted wakeup timer queue.
`timescale 1ns / 1ps

package swtq_pkg;

    localparam int QUEUE_SLOTS  = 16;
    localparam int TASK_ID_BITS = 8;

    localparam int IDX_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(QUEUE_SLOTS + 1);
    localparam int CMD_W   = 2;
    localparam int TASK_W  = 8;
    localparam int SLEEP_W = 32;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL     = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TASK_W-1:0]  task_id;
        logic [SLEEP_W-1:0] sleep_ticks;
        logic [TIME_W-1:0]  now;
    } in_item_t;

    typedef struct packed {
        logic               due_valid;
        logic [TASK_W-1:0]  task_out;
        logic               status;
        logic [TIME_W-1:0]  time_to_next;
        logic [COUNT_W-1:0] queue_count;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [TASK_ID_BITS-1:0] task_id;
        logic [TIME_W-1:0]       wakeup;
    } entry_t;

endpackage

@@ rtl/swtq_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module swtq_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/sorted_wakeup_timer_queue.sv @@
// Top level of the sorted wakeup timer queue: sequencer, shared adder, entry ring.
`timescale 1ns / 1ps
// Flow: schedule computes the wakeup and, unless full, walks in from the tail; remove compacts
//   the ring; poll counts the due prefix; each then reads the first remaining entry, if any.
// Throughput: one item at a time, s_ready low until the last result is loaded; each further
//   popped task is read only once the result register is free.
// Reset: synchronous active-low aresetn empties the queue; entry contents are not cleared.

module sorted_wakeup_timer_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  swtq_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output swtq_pkg::out_item_t  m_data
);

    localparam int IDX_W  = swtq_pkg::IDX_W;
    localparam int CNT_W  = swtq_pkg::CNT_W;
    localparam int TIME_W = swtq_pkg::TIME_W;
    localparam int ID_W   = swtq_pkg::TASK_ID_BITS;

    // Sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_WAKE    = 4'd1;
    localparam logic [3:0] ST_INS_RD  = 4'd2;
    localparam logic [3:0] ST_INS_CMP = 4'd3;
    localparam logic [3:0] ST_RM_RD   = 4'd4;
    localparam logic [3:0] ST_RM_CHK  = 4'd5;
    localparam logic [3:0] ST_PL_RD   = 4'd6;
    localparam logic [3:0] ST_PL_CHK  = 4'd7;
    localparam logic [3:0] ST_GAP_RD  = 4'd8;
    localparam logic [3:0] ST_GAP_CMP = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;
    localparam logic [3:0] ST_EM_RD   = 4'd11;
    localparam logic [3:0] ST_EM_LD   = 4'd12;

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(swtq_pkg::QUEUE_SLOTS);
    localparam logic [IDX_W:0]   SLOTS_SUM = (IDX_W + 1)'(swtq_pkg::QUEUE_SLOTS);

    logic [3:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;   // walk index / emit index
    logic [CNT_W-1:0]              aux_reg, aux_next;   // remove write index / pop count
    logic [swtq_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_W-1:0]               id_reg, id_next;
    logic [swtq_pkg::SLEEP_W-1:0]  sleep_reg, sleep_next;
    logic [TIME_W-1:0]             now_reg, now_next;
    logic [TIME_W-1:0]             wake_reg, wake_next;
    logic [TIME_W-1:0]             gap_reg, gap_next;
    logic                          status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    swtq_pkg::out_item_t           m_data_reg, m_data_next;

    // Entry RAM, addressed as a ring starting at head_reg
    logic                          ram_we, ram_re;
    logic [IDX_W-1:0]              ram_waddr, ram_raddr;
    swtq_pkg::entry_t              ram_wdata, ram_rdata;

    // Shared add/subtract unit; in subtract mode the carry means a >= b
    logic [TIME_W-1:0]             alu_a, alu_b;
    logic                          alu_sub;
    logic [TIME_W:0]               alu_sum;
    logic                          alu_carry;

    logic                          out_free;
    logic                          is_poll;
    logic [CNT_W-1:0]              gap_base;
    logic [3:0]                    after_gap;

    swtq_ram #(
        .WIDTH ($bits(swtq_pkg::entry_t)),
        .DEPTH (swtq_pkg::QUEUE_SLOTS)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Logical slot to RAM address; sum stays below twice the slot count
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] lslot);
        logic [IDX_W:0] s;
        s = {1'b0, head} + (IDX_W + 1)'(lslot);
        if (s >= SLOTS_SUM) begin
            s = s - SLOTS_SUM;
        end
        return s[IDX_W-1:0];
    endfunction

    always_comb begin
        alu_a   = now_reg;
        alu_b   = ram_rdata.wakeup;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_WAKE: begin
                alu_a   = now_reg;
                alu_b   = TIME_W'(sleep_reg);
                alu_sub = 1'b0;
            end
            ST_INS_CMP: begin
                alu_a = wake_reg;
                alu_b = ram_rdata.wakeup;
            end
            ST_GAP_CMP: begin
                alu_a = ram_rdata.wakeup;
                alu_b = now_reg;
            end
            default: begin
                alu_a = now_reg;
                alu_b = ram_rdata.wakeup;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (TIME_W + 1)'(alu_sub);
    assign alu_carry = alu_sum[TIME_W];

    assign out_free  = !m_valid_reg || m_ready;
    assign is_poll   = (cmd_reg == swtq_pkg::CMD_POLL);
    assign gap_base  = is_poll ? aux_reg : '0;
    assign after_gap = (is_poll && aux_reg != '0) ? ST_EM_RD : ST_OUT;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        idx_next     = idx_reg;
        aux_next     = aux_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        sleep_next   = sleep_reg;
        now_next     = now_reg;
        wake_next    = wake_reg;
        gap_next     = gap_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = phys(head_reg, idx_reg);
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = phys(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_data.cmd;
                    id_next     = ID_W'(s_data.task_id);
                    sleep_next  = s_data.sleep_ticks;
                    now_next    = s_data.now;
                    status_next = 1'b0;
                    idx_next    = '0;
                    aux_next    = '0;
                    case (s_data.cmd)
                        swtq_pkg::CMD_SCHEDULE: begin
                            if (count_reg >= SLOTS_CNT) begin
                                status_next = 1'b1;
                                state_next  = ST_GAP_RD;
                            end else begin
                                idx_next   = count_reg;
                                state_next = ST_WAKE;
                            end
                        end
                        swtq_pkg::CMD_REMOVE: begin
                            state_next = ST_RM_RD;
                        end
                        swtq_pkg::CMD_POLL: begin
                            // empty queue: poll gives no result
                            if (count_reg != '0) begin
                                state_next = ST_PL_RD;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WAKE: begin
                wake_next  = alu_carry ? '1 : alu_sum[TIME_W-1:0];
                state_next = ST_INS_RD;
            end

            // Insertion walks down from the tail, moving later entries up one slot
            ST_INS_RD: begin
                if (idx_reg == '0) begin
                    ram_we     = 1'b1;
                    ram_waddr  = phys(head_reg, idx_reg);
                    ram_wdata  = '{task_id: id_reg, wakeup: wake_reg};
                    count_next = count_reg + 1'b1;
                    state_next = ST_GAP_RD;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, idx_reg - 1'b1);
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, idx_reg);
                if (alu_carry) begin
                    // stored wakeup at or before the new one: insert here
                    ram_wdata  = '{task_id: id_reg, wakeup: wake_reg};
                    count_next = count_reg + 1'b1;
                    state_next = ST_GAP_RD;
                end else begin
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
            end

            // Remove compacts survivors toward the head
            ST_RM_RD: begin
                if (idx_reg == count_reg) begin
                    count_next = aux_reg;
                    state_next = ST_GAP_RD;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, idx_reg);
                    state_next = ST_RM_CHK;
                end
            end

            ST_RM_CHK: begin
                if (ram_rdata.task_id != id_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(head_reg, aux_reg);
                    ram_wdata = ram_rdata;
                    aux_next  = aux_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_RM_RD;
            end

            // Poll counts the due prefix; head moves after the tasks are sent
            ST_PL_RD: begin
                if (aux_reg == count_reg) begin
                    count_next = '0;
                    state_next = ST_GAP_RD;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, aux_reg);
                    state_next = ST_PL_CHK;
                end
            end

            ST_PL_CHK: begin
                if (alu_carry) begin
                    aux_next   = aux_reg + 1'b1;
                    state_next = ST_PL_RD;
                end else begin
                    count_next = count_reg - aux_reg;
                    state_next = ST_GAP_RD;
                end
            end

            ST_GAP_RD: begin
                if (count_reg == '0) begin
                    gap_next   = '0;
                    idx_next   = '0;
                    state_next = after_gap;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, gap_base);
                    state_next = ST_GAP_CMP;
                end
            end

            ST_GAP_CMP: begin
                gap_next   = alu_carry ? alu_sum[TIME_W-1:0] : '0;
                idx_next   = '0;
                state_next = after_gap;
            end

            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{due_valid:    1'b0,
                                     task_out:     '0,
                                     status:       status_reg,
                                     time_to_next: gap_reg,
                                     queue_count:  swtq_pkg::COUNT_W'(count_reg),
                                     last:         1'b1};
                    state_next   = ST_IDLE;
                end
            end

            ST_EM_RD: begin
                if (out_free) begin
                    ram_re     = 1'b1;
                    ram_raddr  = phys(head_reg, idx_reg);
                    state_next = ST_EM_LD;
                end
            end

            ST_EM_LD: begin
                m_valid_next = 1'b1;
                m_data_next  = '{due_valid:    1'b1,
                                 task_out:     swtq_pkg::TASK_W'(ram_rdata.task_id),
                                 status:       1'b0,
                                 time_to_next: gap_reg,
                                 queue_count:  swtq_pkg::COUNT_W'(count_reg),
                                 last:         (idx_reg + 1'b1 == aux_reg)};
                if (idx_reg + 1'b1 == aux_reg) begin
                    head_next  = phys(head_reg, aux_reg);
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EM_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        aux_reg    <= aux_next;
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        sleep_reg  <= sleep_next;
        now_reg    <= now_next;
        wake_reg   <= wake_next;
        gap_reg    <= gap_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_CNT)
        else $error("entry count above slot count");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_LD) |-> !m_valid_reg)
        else $error("due task loaded over a pending result");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_CMP) |-> (idx_reg != '0 && count_reg < SLOTS_CNT))
        else $error("insert walk out of range");

    a_poll_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PL_RD) |-> (aux_reg <= count_reg))
        else $error("poll scan past queue tail");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the sorted wakeup timer queue.
`timescale 1ns / 1ps

module tb_top;
    import swtq_pkg::*;

    // Command code that the block ignores. It causes no transfer on the result side.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 345;

    // Shadow copy of the timer table. It predicts the result transfers of each accepted
    // input and checks them in order.
    class timer_queue_scoreboard;
        logic [TASK_ID_BITS-1:0] slot_task [QUEUE_SLOTS];
        logic [TIME_W-1:0]       slot_wake [QUEUE_SLOTS];
        int unsigned             held;
        out_item_t               due_results[$];
        int unsigned             mismatches, checked, dropped_full, popped, peak;
        int unsigned             per_cmd[4];

        function void clear();
            held = 0;
            due_results.delete();
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Queue one predicted result at the tail.
        function void add_expected(out_item_t r);
            due_results = {due_results, r};
        endfunction

        // Ticks from t to the earliest wakeup. Zero if the table is empty or the
        // earliest wakeup is already due.
        function logic [TIME_W-1:0] time_left(logic [TIME_W-1:0] t);
            if (held == 0 || slot_wake[0] <= t) return '0;
            return slot_wake[0] - t;
        endfunction

        function out_item_t make_result(logic due, logic [TASK_W-1:0] id, logic full,
                                        logic [TIME_W-1:0] gap, logic fin);
            out_item_t r;
            r.due_valid    = due;
            r.task_out     = id;
            r.status       = full;
            r.time_to_next = gap;
            r.queue_count  = COUNT_W'(held);
            r.last         = fin;
            return r;
        endfunction

        function void note_input(in_item_t it);
            logic [TASK_ID_BITS-1:0] id;
            logic [TIME_W:0]         sum;
            logic [TIME_W-1:0]       wake, gap;
            logic [TASK_ID_BITS-1:0] due_ids [QUEUE_SLOTS];
            logic                    full;
            int                      pos, keep, n;
            id = it.task_id[TASK_ID_BITS-1:0];
            per_cmd[it.cmd]++;
            case (it.cmd)
                CMD_SCHEDULE: begin
                    full = (held >= QUEUE_SLOTS);
                    if (full) begin
                        dropped_full++;
                    end else begin
                        // wakeup saturates at the top of the time range
                        sum  = {1'b0, it.now} + (TIME_W+1)'(it.sleep_ticks);
                        wake = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                        pos  = 0;
                        // equal wakeups keep scheduling order
                        while (pos < held && slot_wake[pos] <= wake) pos++;
                        for (int i = held; i > pos; i--) begin
                            slot_task[i] = slot_task[i-1];
                            slot_wake[i] = slot_wake[i-1];
                        end
                        slot_task[pos] = id;
                        slot_wake[pos] = wake;
                        held++;
                        if (held > peak) peak = held;
                    end
                    add_expected(make_result(1'b0, '0, full, time_left(it.now), 1'b1));
                end
                CMD_REMOVE: begin
                    keep = 0;
                    for (int i = 0; i < held; i++) begin
                        if (slot_task[i] != id) begin
                            slot_task[keep] = slot_task[i];
                            slot_wake[keep] = slot_wake[i];
                            keep++;
                        end
                    end
                    held = keep;
                    add_expected(make_result(1'b0, '0, 1'b0, time_left(it.now), 1'b1));
                end
                CMD_POLL: begin
                    // an empty table answers a poll with nothing at all
                    if (held == 0) return;
                    n = 0;
                    while (n < held && slot_wake[n] <= it.now) begin
                        due_ids[n] = slot_task[n];
                        n++;
                    end
                    for (int i = n; i < held; i++) begin
                        slot_task[i-n] = slot_task[i];
                        slot_wake[i-n] = slot_wake[i];
                    end
                    held -= n;
                    popped += n;
                    gap = time_left(it.now);
                    if (n == 0)
                        add_expected(make_result(1'b0, '0, 1'b0, gap, 1'b1));
                    for (int k = 0; k < n; k++)
                        add_expected(make_result(1'b1, TASK_W'(due_ids[k]), 1'b0,
                                                 gap, k == n - 1));
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 20)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 20)
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = due_results.pop_front();
            compare_field("due_valid", want.due_valid, got.due_valid);
            compare_field("task_out", want.task_out, got.task_out);
            compare_field("status", want.status, got.status);
            compare_field("time_to_next", want.time_to_next, got.time_to_next);
            compare_field("queue_count", want.queue_count, got.queue_count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    timer_queue_scoreboard sb;

    // Sender state: burst pacing, time base and traffic mode of the random part.
    int                burst_left;
    logic [TIME_W-1:0] clock_ticks;
    bit                fill_mode;

    sorted_wakeup_timer_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // Hard stop in case the block hangs or stops answering.
    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] id,
                                           logic [SLEEP_W-1:0] sleep,
                                           logic [TIME_W-1:0] t);
        in_item_t it;
        it.cmd         = cmd;
        it.task_id     = id;
        it.sleep_ticks = sleep;
        it.now         = t;
        return it;
    endfunction

    // Random item. Time mostly moves forward, with rare jumps anywhere in the range
    // (near the top as well). Fill mode schedules long sleeps to push the table to
    // full. Drain mode polls a lot and moves time faster so that tasks fall due.
    function automatic in_item_t pick_item();
        in_item_t it;
        int       roll;
        it.task_id = TASK_W'($urandom_range(0, 11));
        if ($urandom_range(0, 15) == 0) it.task_id = TASK_W'($urandom);
        it.sleep_ticks = fill_mode ? $urandom_range(0, 2000) : $urandom_range(0, 120);
        case ($urandom_range(0, 9))
            0:       it.sleep_ticks = $urandom;
            1:       it.sleep_ticks = '0;
            default: ;
        endcase
        clock_ticks += fill_mode ? $urandom_range(0, 12) : $urandom_range(0, 80);
        case ($urandom_range(0, 59))
            0:       clock_ticks = {16'($urandom), 32'($urandom)};
            1:       clock_ticks = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 500));
            default: ;
        endcase
        it.now = clock_ticks;
        roll = $urandom_range(0, 99);
        if (fill_mode)
            it.cmd = (roll < 70) ? CMD_SCHEDULE : (roll < 85) ? CMD_REMOVE :
                     (roll < 97) ? CMD_POLL : CMD_UNUSED;
        else
            it.cmd = (roll < 35) ? CMD_SCHEDULE : (roll < 50) ? CMD_REMOVE :
                     (roll < 95) ? CMD_POLL : CMD_UNUSED;
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then either stay in the burst
    // (valid stays high) or drop valid for a random gap. The scoreboard learns the
    // item at the edge where the transfer happens.
    task automatic offer(in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // some bursts are long, so there are stretches with no idling
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    // Result side. Ready follows a pattern that rotates through four modes. Once,
    // after some traffic, it holds off for a long stretch while the sender keeps
    // offering items, so the block backs up and stalls its input.
    initial begin : result_sink
        int cyc;
        int hold_left;
        bit held_once;
        cyc       = 0;
        hold_left = 0;
        held_once = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && sb != null && sb.checked >= 80) begin
                held_once = 1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                case ((cyc / 64) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc % 16) < 11);
                endcase
            end
            cyc++;
        end
    end

    initial begin : stimulus
        in_item_t it;
        int       issued;
        int       loops;
        sb = new();
        sb.clear();
        burst_left  = 0;
        clock_ticks = 48'd1000;
        fill_mode   = 0;
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // A poll on the empty table and an unused code: neither gives a result.
        offer(make_item(CMD_POLL, 8'd0, 32'd0, 48'd1000));
        offer(make_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        // Zero sleep, then an equal wakeup that has to pop after the first one.
        offer(make_item(CMD_SCHEDULE, 8'd0, 32'd0, 48'd1000));
        // Largest sleep at the latest time: the wakeup saturates.
        offer(make_item(CMD_SCHEDULE, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        offer(make_item(CMD_SCHEDULE, 8'd1, 32'd0, 48'd1000));
        // Nothing due yet: one result with no task.
        offer(make_item(CMD_POLL, 8'd0, 32'd0, 48'd999));
        // Both tasks at 1000 fall due, in scheduling order.
        offer(make_item(CMD_POLL, 8'd0, 32'd0, 48'd1000));
        // Remove of an absent id, then of the saturated entry.
        offer(make_item(CMD_REMOVE, 8'd77, 32'd0, 48'd1000));
        offer(make_item(CMD_REMOVE, 8'hFF, 32'd0, 48'd0));
        // Fill all slots with falling sleeps, so every insert goes to the front.
        // Every other entry carries the same id.
        for (int k = 0; k < QUEUE_SLOTS; k++)
            offer(make_item(CMD_SCHEDULE, (k % 2) ? 8'd5 : TASK_W'(k + 16),
                            SLEEP_W'(3000 - 100 * k), 48'd1000));
        // Table full: the schedule is dropped.
        offer(make_item(CMD_SCHEDULE, 8'd9, 32'd10, 48'd1000));
        // Remove takes out every entry with the repeated id.
        offer(make_item(CMD_REMOVE, 8'd5, 32'd0, 48'd1000));
        // Poll at the latest time: every remaining entry pops.
        offer(make_item(CMD_POLL, 8'd0, 32'd0, 48'hFFFF_FFFF_FFFF));

        // Random part. Fill and drain modes alternate at random.
        issued = 0;
        loops  = 0;
        while (issued < RANDOM_ITEMS) begin
            if (loops % 40 == 0) fill_mode = $urandom_range(0, 1);
            loops++;
            it = pick_item();
            offer(it);
            if (it.cmd != CMD_UNUSED) issued++;
        end
        s_valid <= 1'b0;

        // Drain, then allow for a worst-case pass through the table.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("Sent %0d schedules (%0d dropped full), %0d removes, %0d polls, %0d unused.",
                 sb.per_cmd[CMD_SCHEDULE], sb.dropped_full, sb.per_cmd[CMD_REMOVE],
                 sb.per_cmd[CMD_POLL], sb.per_cmd[CMD_UNUSED]);
        $display("Checked %0d results, %0d tasks woke; table held up to %0d of %0d entries.",
                 sb.checked, sb.popped, sb.peak, QUEUE_SLOTS);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
